FILE: rtl/mf3_pkg.sv
// Package for the 3x3 median filter: sizes, register indexes and shared types.
// Used by every module of the block; depends on nothing.
`default_nettype none
package mf3_pkg;
  localparam int MAX_WIDTH = 2048;
  localparam int COL_W     = $clog2(MAX_WIDTH);
  localparam int WID_W     = 12;
  localparam int HGT_W     = 16;
  localparam int ROW_W     = HGT_W + 1;
  localparam int PIX_W     = 8;
  localparam int IDX_W     = 2;
  localparam int DATA_W    = 16;
  localparam int TAPS      = 9;
  localparam int RANK_W    = 4;

  localparam logic [WID_W-1:0] WIDTH_RESET  = WID_W'(640);
  localparam logic [HGT_W-1:0] HEIGHT_RESET = HGT_W'(480);

  typedef enum logic [IDX_W-1:0] {
    REG_IMAGE_WIDTH  = 2'd0,
    REG_IMAGE_HEIGHT = 2'd1
  } reg_index_t;

  typedef logic [PIX_W-1:0] pix_t;
  typedef pix_t [TAPS-1:0] window_t;

  typedef struct packed {
    logic valid;
    logic last;
    logic [TAPS-1:0] incl;
    logic [RANK_W-1:0] half;
    logic [TAPS-1:0][RANK_W-1:0] rank;
    window_t vals;
  } rank_stage_t;
endpackage
`default_nettype wire

FILE: rtl/median_filter_3x3_top.sv
// 3x3 median filter top level: positions, window, line stores, selection.
// Uses mf3_pkg, mf3_line_store and mf3_rank.
// Throughput: one item per cycle; the whole pipeline stalls only on m_axis_tready.
// Stages in order: s1 registers and line-store read, window shift (s2), rank registers (s3), output register.
// Results trail the pixels by image_width+1 items; drain items flush the last row.
// Reset: synchronous; positions and window clear, sizes go to 640 by 480, line stores keep data.
`default_nettype none
module median_filter_3x3_top (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        s_axis_tvalid,
  output logic                             s_axis_tready,
  input  wire logic [7:0]                  s_axis_tdata,  // pixel_value
  input  wire logic                        s_axis_tuser,  // kind
  output logic                             m_axis_tvalid,
  input  wire logic                        m_axis_tready,
  output logic [7:0]                       m_axis_tdata,  // median_value
  output logic                             m_axis_tlast,
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic [mf3_pkg::IDX_W-1:0]   cfg_index,
  input  wire logic [mf3_pkg::DATA_W-1:0]  cfg_data
);
  import mf3_pkg::*;

  logic [WID_W-1:0] image_width;
  logic [HGT_W-1:0] image_height;
  logic [WID_W-1:0] w_eff;
  logic [HGT_W-1:0] h_eff;
  logic [COL_W-1:0] in_col;
  logic [ROW_W-1:0] in_row;
  logic [COL_W-1:0] out_col;
  logic [ROW_W-1:0] out_row;
  logic adv, accept, flushing, take, emit, last, col_end, out_col_end, cfg_write;
  logic [TAPS-1:0] mask;
  pix_t pix;

  logic s1_valid, s1_emit, s1_last;
  logic [COL_W-1:0] s1_col;
  pix_t s1_pix;
  logic [TAPS-1:0] s1_mask;
  pix_t top, mid;

  window_t window;
  logic s2_valid, s2_last;
  logic [TAPS-1:0] s2_mask;
  rank_stage_t s3;
  logic [TAPS-1:0] hit;
  pix_t median;

  assign w_eff = (image_width == '0) ? WID_W'(1) :
                 (image_width > WID_W'(MAX_WIDTH)) ? WID_W'(MAX_WIDTH) : image_width;
  assign h_eff = (image_height == '0) ? HGT_W'(1) : image_height;

  assign adv           = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = adv;
  assign cfg_ready     = 1'b1;
  assign cfg_write     = cfg_valid && cfg_ready;
  assign accept        = s_axis_tvalid && adv;
  assign flushing      = in_row >= ROW_W'(h_eff);
  assign take          = accept && (flushing || !s_axis_tuser);
  assign pix           = flushing ? '0 : s_axis_tdata;
  assign emit          = (in_row >= ROW_W'(2)) || ((in_row == ROW_W'(1)) && (in_col != '0));
  assign col_end       = (WID_W'(in_col) + WID_W'(1)) >= w_eff;
  assign out_col_end   = (WID_W'(out_col) + WID_W'(1)) >= w_eff;
  assign last          = ((out_row + ROW_W'(1)) >= ROW_W'(h_eff)) && out_col_end;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      for (int m = 0; m < 3; m++) begin
        mask[k*3+m] = !((k == 0) && (out_col == '0)) && !((k == 2) && out_col_end) &&
                      !((m == 0) && (out_row == '0)) &&
                      !((m == 2) && ((out_row + ROW_W'(1)) >= ROW_W'(h_eff)));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= WIDTH_RESET;
      image_height <= HEIGHT_RESET;
      in_col  <= '0;
      in_row  <= '0;
      out_col <= '0;
      out_row <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_IMAGE_WIDTH: begin
          image_width <= cfg_data[WID_W-1:0];
          in_col  <= '0;
          in_row  <= '0;
          out_col <= '0;
          out_row <= '0;
        end
        REG_IMAGE_HEIGHT: begin
          image_height <= cfg_data[HGT_W-1:0];
          in_col  <= '0;
          in_row  <= '0;
          out_col <= '0;
          out_row <= '0;
        end
        default: begin
        end
      endcase
    end else if (take) begin
      if (emit && last) begin
        in_col  <= '0;
        in_row  <= '0;
        out_col <= '0;
        out_row <= '0;
      end else begin
        if (col_end) begin
          in_col <= '0;
          in_row <= in_row + ROW_W'(1);
        end else begin
          in_col <= in_col + COL_W'(1);
        end
        if (emit) begin
          if (out_col_end) begin
            out_col <= '0;
            out_row <= out_row + ROW_W'(1);
          end else begin
            out_col <= out_col + COL_W'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= take;
    end
    if (adv) begin
      s1_emit <= emit;
      s1_last <= last;
      s1_col  <= in_col;
      s1_pix  <= pix;
      s1_mask <= mask;
    end
  end

  mf3_line_store u_line_store (
    .clk       (clk),
    .rd_en     (take),
    .rd_addr   (in_col),
    .wr_en     (adv && s1_valid),
    .wr_addr   (s1_col),
    .wr_upper  (mid),
    .wr_middle (s1_pix),
    .top       (top),
    .mid       (mid)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      window   <= '0;
      s2_valid <= 1'b0;
    end else if (adv) begin
      s2_valid <= s1_valid && s1_emit;
      if (s1_valid) begin
        for (int k = 0; k < 6; k++) begin
          window[k] <= window[k+3];
        end
        window[6] <= top;
        window[7] <= mid;
        window[8] <= s1_pix;
      end
    end
    if (adv) begin
      s2_last <= s1_last;
      s2_mask <= s1_mask;
    end
  end

  mf3_rank u_rank (
    .clk    (clk),
    .rst    (rst),
    .en     (adv),
    .valid  (s2_valid),
    .last   (s2_last),
    .mask   (s2_mask),
    .window (window),
    .stage  (s3)
  );

  always_comb begin
    median = '0;
    for (int i = 0; i < TAPS; i++) begin
      hit[i] = s3.incl[i] && (s3.rank[i] == s3.half);
      if (hit[i]) begin
        median = s3.vals[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (adv) begin
      m_axis_tvalid <= s3.valid;
    end
    if (adv) begin
      m_axis_tdata <= median;
      m_axis_tlast <= s3.last;
    end
  end

  a_col_in_range: assert property (@(posedge clk) disable iff (rst)
    WID_W'(in_col) < w_eff) else $error("input column beyond image width");
  a_single_median: assert property (@(posedge clk) disable iff (rst)
    s3.valid |-> $onehot(hit)) else $error("median rank not selected exactly once");
  a_restart_after_last: assert property (@(posedge clk) disable iff (rst)
    (take && emit && last && !cfg_write) |=> (in_col == '0 && in_row == '0 && out_row == '0))
    else $error("positions not restarted after end of image");
  a_stall_holds_s1: assert property (@(posedge clk) disable iff (rst)
    (!adv && s1_valid) |=> s1_valid) else $error("stage one item lost during stall");
endmodule
`default_nettype wire

FILE: rtl/mf3_line_store.sv
// Two line stores in synchronous memories with registered reads.
// Forwards the value written at the same edge as a read of the same column.
`default_nettype none
module mf3_line_store (
  input  wire logic                      clk,
  input  wire logic                      rd_en,
  input  wire logic [mf3_pkg::COL_W-1:0] rd_addr,
  input  wire logic                      wr_en,
  input  wire logic [mf3_pkg::COL_W-1:0] wr_addr,
  input  wire mf3_pkg::pix_t             wr_upper,
  input  wire mf3_pkg::pix_t             wr_middle,
  output mf3_pkg::pix_t                  top,
  output mf3_pkg::pix_t                  mid
);
  import mf3_pkg::*;

  pix_t upper_mem [MAX_WIDTH];
  pix_t middle_mem [MAX_WIDTH];
  pix_t upper_dout;
  pix_t middle_dout;
  logic fwd_hit;
  pix_t fwd_upper;
  pix_t fwd_middle;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      upper_mem[wr_addr]  <= wr_upper;
      middle_mem[wr_addr] <= wr_middle;
    end
    if (rd_en) begin
      upper_dout  <= upper_mem[rd_addr];
      middle_dout <= middle_mem[rd_addr];
      fwd_hit     <= wr_en && (wr_addr == rd_addr);
      fwd_upper   <= wr_upper;
      fwd_middle  <= wr_middle;
    end
  end

  assign top = fwd_hit ? fwd_upper : upper_dout;
  assign mid = fwd_hit ? fwd_middle : middle_dout;
endmodule
`default_nettype wire

FILE: rtl/mf3_rank.sv
// Rank stage: orders the in-image window values, ties broken by tap position.
// Uses mf3_pkg; registers the ranks and the wanted rank for the selection.
`default_nettype none
module mf3_rank (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        en,
  input  wire logic                        valid,
  input  wire logic                        last,
  input  wire logic [mf3_pkg::TAPS-1:0]    mask,
  input  wire mf3_pkg::window_t            window,
  output mf3_pkg::rank_stage_t             stage
);
  import mf3_pkg::*;

  logic [TAPS-1:0][RANK_W-1:0] rank_next;
  logic [RANK_W-1:0] count;

  always_comb begin
    count = '0;
    for (int i = 0; i < TAPS; i++) begin
      count = count + RANK_W'(mask[i]);
    end
    for (int i = 0; i < TAPS; i++) begin
      rank_next[i] = '0;
      for (int j = 0; j < TAPS; j++) begin
        if (mask[j] && ((window[j] < window[i]) || ((window[j] == window[i]) && (j < i)))) begin
          rank_next[i] = rank_next[i] + RANK_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage.valid <= 1'b0;
    end else if (en) begin
      stage.valid <= valid;
    end
    if (en) begin
      stage.last <= last;
      stage.incl <= mask;
      stage.half <= count >> 1;
      stage.rank <= rank_next;
      stage.vals <= window;
    end
  end
endmodule
`default_nettype wire

FILE: verif/median_filter_3x3_checker.sv
// Checker for the 3x3 median filter: watches the pixel, result and register channels,
// predicts each result from its own copy of the filter state and compares field by field.
// Depends on mf3_pkg for the register indexes and sizes.
`timescale 1ns / 1ps
module median_filter_3x3_checker (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       s_axis_tvalid,
  input  wire logic                       s_axis_tready,
  input  wire logic [7:0]                 s_axis_tdata,
  input  wire logic                       s_axis_tuser,
  input  wire logic                       m_axis_tvalid,
  input  wire logic                       m_axis_tready,
  input  wire logic [7:0]                 m_axis_tdata,
  input  wire logic                       m_axis_tlast,
  input  wire logic                       cfg_valid,
  input  wire logic                       cfg_ready,
  input  wire logic [mf3_pkg::IDX_W-1:0]  cfg_index,
  input  wire logic [mf3_pkg::DATA_W-1:0] cfg_data,
  output int                              mismatches,
  output int                              pending
);
  import mf3_pkg::*;

  typedef struct {
    logic [7:0] median;
    logic       eoi;
  } filtered_pixel_t;

  filtered_pixel_t filtered_q[$];

  logic [7:0]  upper_row [MAX_WIDTH];
  logic [7:0]  middle_row [MAX_WIDTH];
  logic [7:0]  window [TAPS];
  logic [11:0] width_reg;
  logic [15:0] height_reg;
  int          in_col, in_row, out_col, out_row;

  assign pending = filtered_q.size();

  function automatic int eff_width();
    int w;
    w = (width_reg == 0) ? 1 : int'(width_reg);
    if (w > MAX_WIDTH) w = MAX_WIDTH;
    return w;
  endfunction

  function automatic int eff_height();
    return (height_reg == 0) ? 1 : int'(height_reg);
  endfunction

  task automatic restart_image();
    in_col = 0;
    in_row = 0;
    out_col = 0;
    out_row = 0;
  endtask

  task automatic predict_pixel(input logic kind, input logic [7:0] pix);
    int w, h, ci, ri, ro, co, n, k, m;
    bit flushing, emit, last;
    logic [7:0] v, top, mid, x;
    logic [7:0] vals [9];
    filtered_pixel_t r;
    w = eff_width();
    h = eff_height();
    flushing = (in_row >= h);
    ci = in_col;
    ri = in_row;
    n = 0;
    if (!flushing && kind) return;
    v = flushing ? 8'd0 : pix;
    top = upper_row[ci];
    mid = middle_row[ci];
    upper_row[ci] = mid;
    middle_row[ci] = v;
    for (k = 0; k < 6; k++) window[k] = window[k + 3];
    window[6] = top;
    window[7] = mid;
    window[8] = v;
    emit = (ri >= 2) || (ri == 1 && ci >= 1);
    if (ci + 1 >= w) begin
      in_col = 0;
      in_row = ri + 1;
    end else begin
      in_col = ci + 1;
    end
    if (!emit) return;
    ro = out_row;
    co = out_col;
    for (k = 0; k < 3; k++) begin
      if (k == 0 && co == 0) continue;
      if (co + k - 1 >= w) continue;
      for (m = 0; m < 3; m++) begin
        if (m == 0 && ro == 0) continue;
        if (ro + m - 1 >= h) continue;
        vals[n] = window[k * 3 + m];
        n++;
      end
    end
    for (k = 1; k < n; k++) begin
      x = vals[k];
      m = k;
      while (m > 0 && vals[m - 1] > x) begin
        vals[m] = vals[m - 1];
        m--;
      end
      vals[m] = x;
    end
    last = (ro + 1 >= h) && (co + 1 >= w);
    r.median = (n > 0) ? vals[n / 2] : 8'd0;
    r.eoi = last;
    filtered_q.push_back(r);
    if (last) begin
      restart_image();
    end else if (co + 1 >= w) begin
      out_col = 0;
      out_row = ro + 1;
    end else begin
      out_col = co + 1;
    end
  endtask

  always @(posedge clk) begin
    filtered_pixel_t exp_px;
    if (rst) begin
      width_reg <= WIDTH_RESET;
      height_reg <= HEIGHT_RESET;
      for (int i = 0; i < MAX_WIDTH; i++) begin
        upper_row[i] = 8'd0;
        middle_row[i] = 8'd0;
      end
      for (int i = 0; i < TAPS; i++) window[i] = 8'd0;
      restart_image();
      filtered_q.delete();
      mismatches <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_IMAGE_WIDTH) begin
          width_reg <= cfg_data[11:0];
          restart_image();
        end else if (cfg_index == REG_IMAGE_HEIGHT) begin
          height_reg <= cfg_data[15:0];
          restart_image();
        end
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (filtered_q.size() == 0) begin
          if (mismatches < 10)
            $display("%0t: unexpected result transfer median=%0d last=%0b", $realtime,
                     m_axis_tdata, m_axis_tlast);
          mismatches <= mismatches + 1;
        end else begin
          exp_px = filtered_q.pop_front();
          if (exp_px.median !== m_axis_tdata || exp_px.eoi !== m_axis_tlast) begin
            if (mismatches < 10)
              $display({"%0t: result mismatch: expected median=%0d last=%0b, ",
                        "got median=%0d last=%0b"},
                       $realtime, exp_px.median, exp_px.eoi, m_axis_tdata, m_axis_tlast);
            mismatches <= mismatches + 1;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) predict_pixel(s_axis_tuser, s_axis_tdata);
    end
  end

endmodule

FILE: verif/testbench.sv
// Testbench top for the 3x3 median filter: clock, reset, pixel and register stimulus,
// receiver stalls, watchdog and verdict. Depends on mf3_pkg, median_filter_3x3_top and median_filter_3x3_checker.
`timescale 1ns / 1ps
module testbench;
  import mf3_pkg::*;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [7:0]        s_axis_tdata = 8'd0;
  logic              s_axis_tuser = 1'b0;
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [7:0]        m_axis_tdata;
  logic              m_axis_tlast;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [IDX_W-1:0]  cfg_index = REG_IMAGE_WIDTH;
  logic [DATA_W-1:0] cfg_data = '0;
  int                mismatches;
  int                pending;
  int                sent_items = 0;
  int                cur_w = 640;
  int                cur_h = 480;
  bit                quiet = 1'b0;
  bit                hold_req = 1'b0;
  int                idle_cycles = 0;

  always #6 clk = ~clk;

  median_filter_3x3_top u_dut (.*);

  median_filter_3x3_checker u_checker (.*);

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Receiver: random ready/stall runs, plus one long hold-off on request.
  initial begin
    int run_len;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        m_axis_tready <= 1'b0;
        repeat (400) @(negedge clk);
        hold_req = 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        run_len = $urandom_range(0, 40);
        repeat (run_len) @(negedge clk);
        run_len = pick_gap();
        if (run_len > 0) begin
          m_axis_tready <= 1'b0;
          repeat (run_len - 1) @(negedge clk);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready) || rst) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= 5000) begin
      $display("FAIL median_filter_3x3_top");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_pixel(input logic kind, input logic [7:0] pix);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= kind;
    s_axis_tdata <= pix;
    do @(posedge clk); while (!s_axis_tready);
    @(negedge clk);
    sent_items++;
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (12) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(input reg_index_t idx, input logic [DATA_W-1:0] value);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_size(input logic [DATA_W-1:0] w, input logic [DATA_W-1:0] h);
    write_reg(REG_IMAGE_WIDTH, w);
    write_reg(REG_IMAGE_HEIGHT, h);
    cur_w = (w[11:0] == 0) ? 1 : ((w[11:0] > MAX_WIDTH) ? MAX_WIDTH : int'(w[11:0]));
    cur_h = (h == 0) ? 1 : int'(h);
  endtask

  // One full image: pixels with occasional ignored drain ticks, then the flush items,
  // some of which are surplus pixels that act as drains.
  task automatic run_image(input int early_drain_pct, input int hold_at);
    for (int i = 0; i < cur_w * cur_h; i++) begin
      if (i == hold_at) hold_req = 1'b1;
      if ($urandom_range(0, 99) < early_drain_pct) send_pixel(1'b1, 8'($urandom));
      send_pixel(1'b0, 8'($urandom));
    end
    for (int i = 0; i <= cur_w; i++)
      send_pixel(1'($urandom_range(0, 1)), 8'($urandom));
  endtask

  initial begin
    int w, h;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    set_size(16'd3, 16'd3);
    send_pixel(1'b1, 8'hff);
    send_pixel(1'b0, 8'h00);
    send_pixel(1'b0, 8'hff);
    send_pixel(1'b0, 8'h00);
    send_pixel(1'b0, 8'hff);
    send_pixel(1'b1, 8'h00);
    send_pixel(1'b0, 8'h80);
    send_pixel(1'b0, 8'h7f);
    send_pixel(1'b0, 8'h01);
    send_pixel(1'b0, 8'hfe);
    send_pixel(1'b0, 8'h55);
    send_pixel(1'b0, 8'hff);
    send_pixel(1'b1, 8'haa);
    send_pixel(1'b1, 8'h00);
    send_pixel(1'b0, 8'h33);
    set_size(16'd0, 16'd0);
    send_pixel(1'b0, 8'hc3);
    send_pixel(1'b1, 8'h00);
    send_pixel(1'b0, 8'h3c);
    send_pixel(1'b0, 8'h00);
    // A size write in the middle of an image restarts it.
    set_size(16'd4, 16'd4);
    for (int i = 0; i < 6; i++) send_pixel(1'b0, 8'($urandom));
    set_size(16'd2, 16'd5);
    run_image(0, -1);

    // An oversized width saturates; the image is cut short by the next size write.
    set_size(16'hffff, 16'd1);
    for (int i = 0; i < 60; i++) send_pixel(1'b0, 8'($urandom));
    // Only the low twelve bits of the width register are kept.
    set_size(16'h1003, 16'd3);
    run_image(2, -1);
    set_size(16'd1, 16'd200);
    quiet = 1'b1;
    run_image(2, 100);
    quiet = 1'b0;

    while (sent_items < 1000) begin
      if ($urandom_range(0, 3) != 0) begin
        w = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 40) : $urandom_range(1, 8);
        h = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 20) : $urandom_range(1, 6);
        if ($urandom_range(0, 1)) write_reg(REG_IMAGE_HEIGHT, 16'(h)); else h = cur_h;
        set_size(16'(w), 16'(h));
      end
      quiet = ($urandom_range(0, 4) == 0);
      run_image($urandom_range(0, 8), -1);
      if ($urandom_range(0, 4) == 0) wait_drained();
    end

    wait_drained();
    repeat (20) @(posedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("PASS median_filter_3x3_top");
    end else begin
      $display("FAIL median_filter_3x3_top");
    end
    $finish;
  end

endmodule

FILE: median_filter_3x3_top.f
rtl/mf3_pkg.sv
rtl/mf3_line_store.sv
rtl/mf3_rank.sv
rtl/median_filter_3x3_top.sv
verif/median_filter_3x3_checker.sv
verif/testbench.sv
